// ===== hdl/bpc_pkg.sv =====
// Shared widths, types and register indexes of the boundary pixel counter.
package bpc_pkg;

  localparam int unsigned MAX_COLS = 1024;
  localparam int unsigned MAX_ROWS = 1024;

  localparam int unsigned COL_W     = $clog2(MAX_COLS);
  localparam int unsigned ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned COUNT_W   = 21;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ENTRY_W   = 2;

  typedef logic [SIZE_W-1:0]    size_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [COL_W-1:0]     col_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [ENTRY_W-1:0]   entry_t;

  localparam cfg_idx_t CFG_ROW_COUNT = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_COL_COUNT = cfg_idx_t'(1);

endpackage

// ===== hdl/bpc_if.sv =====
// Valid/ready channel interfaces: pixel input, count output, register writes.
interface bpc_pixel_if;
  logic valid;
  logic ready;
  logic is_land;

  modport source (output valid, output is_land, input ready);
  modport sink   (input valid, input is_land, output ready);
endinterface

interface bpc_count_if;
  logic                 valid;
  logic                 ready;
  logic [bpc_pkg::COUNT_W-1:0] coast_count;

  modport source (output valid, output coast_count, input ready);
  modport sink   (input valid, input coast_count, output ready);
endinterface

interface bpc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bpc_pkg::CFG_IDX_W-1:0] index;
  logic [bpc_pkg::SIZE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/bpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/boundary_pixel_counter_top.sv =====
// Top level of the boundary pixel counter: raster window, line store and count.
//
//   channel  | dir | payload                      | accepted when
//   ---------+-----+------------------------------+----------------------
//   cfg_i    | in  | index (2b), data (11b)       | cfg_i.valid & ready
//   pix_i    | in  | is_land (1b)                 | pix_i.valid & ready
//   cnt_o    | out | coast_count (21b)            | cnt_o.valid & ready
//
// One pixel item per cycle while no finished count waits at the output; the frame
// count appears on cnt_o in the cycle after the last pixel of the frame is taken.
// The pace is set by the line store: one write and one read port per cycle.
// Reset gives a 1 x 1 map; no clearing pass is needed after reset.
// pix_i stalls only while a finished count waits and cnt_o is not ready.
// cfg_i is always ready; a write to a known register restarts the frame.
module boundary_pixel_counter_top (
  input logic         clk_i,
  input logic         rst_ni,
  bpc_cfg_if.sink     cfg_i,
  bpc_pixel_if.sink   pix_i,
  bpc_count_if.source cnt_o
);
  import bpc_pkg::*;

  // Size minus one, clamped to the legal range (zero acts as one).
  function automatic int unsigned clamp_m1(size_t v, int unsigned maxv);
    if (v == '0) begin
      return 0;
    end
    if (32'(v) > maxv) begin
      return maxv - 1;
    end
    return 32'(v) - 1;
  endfunction

  // Frame geometry, stored as last index.
  row_t   rows_m1_q;
  col_t   cols_m1_q;

  // Raster position of the next pixel and the running total.
  row_t   row_pos_q, row_pos_d;
  col_t   col_pos_q, col_pos_d;
  count_t running_q, running_d;

  // Window: cur_q holds the line entry of the current column, the RAM read
  // port holds the entry one column ahead, left_q the center bit one to the
  // left. Entry bit 0 is the row above, bit 1 two rows above.
  entry_t cur_q, cur_d;
  entry_t col0_q;
  logic   left_q;
  entry_t nxt_entry;

  // Result register.
  logic   out_valid_q, out_valid_d;
  count_t coast_q;

  logic   cfg_acc, cfg_hit, pix_acc;
  logic   land, center, up, right;
  logic   col_first, col_last, row_first, row_last, frame_end;
  logic   interior, edge_hit, inner_hit;
  count_t count_next;
  entry_t wr_entry;
  col_t   raddr;

  bpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (2 ** COL_W)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (pix_acc),
    .waddr_i (col_pos_q),
    .wdata_i (wr_entry),
    .raddr_i (raddr),
    .rdata_o (nxt_entry)
  );

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid & cfg_i.ready;
  assign cfg_hit     = cfg_acc &&
                       (cfg_i.index == CFG_ROW_COUNT || cfg_i.index == CFG_COL_COUNT);

  // Take a new pixel unless a finished count is stuck at the output.
  assign pix_i.ready = ~out_valid_q | cnt_o.ready;
  assign pix_acc     = pix_i.valid & pix_i.ready;

  assign cnt_o.valid       = out_valid_q;
  assign cnt_o.coast_count = coast_q;

  always_comb begin
    land      = pix_i.is_land;
    col_first = (col_pos_q == '0);
    col_last  = (col_pos_q == cols_m1_q);
    row_first = (row_pos_q == '0);
    row_last  = (row_pos_q == rows_m1_q);
    frame_end = col_last & row_last;

    center = cur_q[0];
    up     = cur_q[1];
    right  = col_last ? 1'b0 : nxt_entry[0];

    // Frame-edge land counts on arrival.
    edge_hit  = land & (row_first | row_last | col_first | col_last);
    // The pixel above is interior once its lower neighbor shows up.
    interior  = (row_pos_q > row_t'(1)) & ~col_first & ~col_last;
    inner_hit = interior & center & (~up | ~land | ~left_q | ~right);

    count_next = running_q + count_t'(edge_hit) + count_t'(inner_hit);
    wr_entry   = {center, land};

    // Prefetch: keep the read port one column ahead of the position.
    if (pix_acc) begin
      raddr = col_last ? col_t'(1) : col_pos_q + col_t'(2);
    end else begin
      raddr = col_pos_q + col_t'(1);
    end

    // Advance the window; on a row wrap pull column 0 from its shadow.
    cur_d = cur_q;
    if (pix_acc) begin
      if (col_last) begin
        cur_d = col_first ? wr_entry : col0_q;
      end else begin
        cur_d = nxt_entry;
      end
    end

    row_pos_d = row_pos_q;
    col_pos_d = col_pos_q;
    running_d = running_q;
    if (cfg_hit) begin
      row_pos_d = '0;
      col_pos_d = '0;
      running_d = '0;
    end else if (pix_acc) begin
      if (frame_end) begin
        row_pos_d = '0;
        col_pos_d = '0;
        running_d = '0;
      end else if (col_last) begin
        row_pos_d = row_pos_q + row_t'(1);
        col_pos_d = '0;
        running_d = count_next;
      end else begin
        col_pos_d = col_pos_q + col_t'(1);
        running_d = count_next;
      end
    end

    out_valid_d = (out_valid_q & ~cnt_o.ready) | (pix_acc & frame_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m1_q   <= '0;
      cols_m1_q   <= '0;
      row_pos_q   <= '0;
      col_pos_q   <= '0;
      running_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_i.index)
          CFG_ROW_COUNT: rows_m1_q <= row_t'(clamp_m1(cfg_i.data, MAX_ROWS));
          CFG_COL_COUNT: cols_m1_q <= col_t'(clamp_m1(cfg_i.data, MAX_COLS));
          default: ;
        endcase
      end
      row_pos_q   <= row_pos_d;
      col_pos_q   <= col_pos_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Window and result payload: no reset needed.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (pix_acc) begin
      left_q <= center;
      if (col_first) begin
        col0_q <= wr_entry;
      end
      if (frame_end) begin
        coast_q <= count_next;
      end
    end
  end

`ifndef SYNTHESIS
  // The last pixel of a frame loads a count and rewinds the raster.
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc && frame_end && !cfg_hit |=> out_valid_q && row_pos_q == '0 && col_pos_q == '0)
    else $error("frame end did not emit a count and rewind");

  // The raster position stays inside the configured frame.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_pos_q <= cols_m1_q && row_pos_q <= rows_m1_q)
    else $error("raster position beyond frame size");

  // A register write drops the frame in progress.
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> running_q == '0 && col_pos_q == '0 && row_pos_q == '0)
    else $error("register write did not restart the frame");
`endif

endmodule

// ===== verif/boundary_pixel_counter_top_tb.sv =====
// Self-checking testbench for the boundary pixel counter top level.
`timescale 1ns / 1ps

module boundary_pixel_counter_top_tb;
  import bpc_pkg::*;

  // Register indexes that the block does not decode; writes there must not
  // disturb a frame in progress.
  localparam cfg_idx_t CFG_SPARE_LO = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_SPARE_HI = cfg_idx_t'(3);

  localparam int unsigned ITEM_TARGET   = 1900;
  localparam int unsigned CALM_TAIL     = 200;  // last items of the run, no idling
  localparam int unsigned LONG_HOLD     = 300;  // receiver hold-off, in cycles
  localparam int unsigned SETTLE_CYCLES = 4;    // count shows in the cycle after the last item
  localparam int unsigned DRAIN_CYCLES  = 10;

  logic clk_i;
  logic rst_ni;

  bpc_cfg_if   cfg_ch ();
  bpc_pixel_if pix_ch ();
  bpc_count_if cnt_ch ();

  boundary_pixel_counter_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .pix_i  (pix_ch),
    .cnt_o  (cnt_ch)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Coast predictor: its own copy of the line store, raster position, the
  // up-left cell, the running tally and both size registers.
  // ---------------------------------------------------------------------------
  entry_t      line_store [MAX_COLS];
  int unsigned pos_row;
  int unsigned pos_col;
  logic        up_left;
  count_t      tally;
  size_t       rows_reg;
  size_t       cols_reg;

  count_t expected_counts [$];  // frame totals still owed by the block
  bit     land_queue [$];       // pixel items not yet offered
  int unsigned failures;
  int unsigned counts_checked;
  int unsigned cells_queued;
  int unsigned reg_writes;

  // Idle controls, set per phase by the stimulus process.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req;

  // A size of zero acts as one; anything above the cap acts as the cap.
  function automatic int unsigned eff_size(size_t v, int unsigned cap);
    if (v == '0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic void restart_frame();
    pos_row = 0;
    pos_col = 0;
    up_left = 1'b0;
    tally   = '0;
  endfunction

  function automatic void reset_predictor();
    for (int i = 0; i < MAX_COLS; i++) line_store[i] = '0;
    restart_frame();
    rows_reg = size_t'(1);
    cols_reg = size_t'(1);
  endfunction

  function automatic void apply_register(cfg_idx_t idx, size_t value);
    case (idx)
      CFG_ROW_COUNT: begin
        rows_reg = value;
        restart_frame();
      end
      CFG_COL_COUNT: begin
        cols_reg = value;
        restart_frame();
      end
      default: ;
    endcase
  endfunction

  // Advance the raster by one cell; returns 1 with the frame total when the
  // cell closes the frame.
  function automatic bit tally_cell(logic land, output count_t total);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    entry_t      e;
    logic        right_bit;
    count_t      t;
    rows  = eff_size(rows_reg, MAX_ROWS);
    cols  = eff_size(cols_reg, MAX_COLS);
    r     = pos_row;
    c     = pos_col;
    t     = tally;
    total = '0;
    // Frame edge cells are coast as soon as they arrive.
    if (land && (r == 0 || r == rows - 1 || c == 0 || c == cols - 1)) t = t + 1'b1;
    e         = line_store[c];
    right_bit = (c + 1 < cols) ? line_store[c + 1][0] : 1'b0;
    // Interior cell one row up is decided now that its lower neighbor is here.
    if (r >= 2 && c >= 1 && c + 1 < cols && e[0] &&
        (!e[1] || !land || !up_left || !right_bit)) t = t + 1'b1;
    up_left       = e[0];
    line_store[c] = {e[0], land};
    tally         = t;
    if (c + 1 < cols) begin
      pos_col = c + 1;
      return 1'b0;
    end
    pos_col = 0;
    if (r + 1 < rows) begin
      pos_row = r + 1;
      return 1'b0;
    end
    total = tally;
    restart_frame();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver: offer queued items, with random idle bursts between them.
  // ---------------------------------------------------------------------------
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_ch.valid   <= 1'b0;
      pix_ch.is_land <= 1'b0;
      gap_left       <= 0;
    end else if (!pix_ch.valid || pix_ch.ready) begin
      // The previous item (if any) was taken; pick what to offer next.
      if (gap_left != 0) begin
        gap_left     <= gap_left - 1;
        pix_ch.valid <= 1'b0;
      end else if (land_queue.size() != 0) begin
        if ($urandom_range(0, 99) < send_idle_pct) begin
          gap_left     <= $urandom_range(0, 8);
          pix_ch.valid <= 1'b0;
        end else begin
          pix_ch.valid   <= 1'b1;
          pix_ch.is_land <= land_queue.pop_front();
        end
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Count receiver: random stall bursts, plus a long hold-off on request that
  // is counted here so the block backs up onto its pixel input.
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  int unsigned hold_seen;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_ch.ready <= 1'b0;
      stall_left   <= 0;
      hold_seen    <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      stall_left   <= LONG_HOLD - 1;
      cnt_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      cnt_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      stall_left   <= $urandom_range(0, 8);
      cnt_ch.ready <= 1'b0;
    end else begin
      cnt_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: track register writes and pixel items, predict frame totals and
  // compare every count the block hands over against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    count_t total;
    count_t want;
    if (!rst_ni) begin
      reset_predictor();
      expected_counts.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_register(cfg_ch.index, cfg_ch.data);
      if (pix_ch.valid && pix_ch.ready) begin
        if (tally_cell(pix_ch.is_land, total)) expected_counts.push_back(total);
      end
      if (cnt_ch.valid && cnt_ch.ready) begin
        if (expected_counts.size() == 0) begin
          $error("coast_count: expected none pending, actual %0d", cnt_ch.coast_count);
          failures++;
        end else begin
          want = expected_counts.pop_front();
          counts_checked++;
          if (cnt_ch.coast_count !== want) begin
            $error("coast_count: expected %0d, actual %0d", want, cnt_ch.coast_count);
            failures++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Hold until every queued item is taken and every count has come back, then
  // let the block finish any partial work.
  task automatic settle();
    while (land_queue.size() != 0 || pix_ch.valid || expected_counts.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(cfg_idx_t idx, size_t value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic queue_cells(int unsigned n, int unsigned land_pct);
    repeat (n) land_queue.push_back($urandom_range(0, 99) < land_pct);
    cells_queued += n;
  endtask

  // 3 x 3 frame, top-left cell in the MSB.
  task automatic queue_pattern(bit [8:0] pat);
    for (int i = 8; i >= 0; i--) land_queue.push_back(pat[i]);
    cells_queued += 9;
  endtask

  // Program one map size and stream whole frames through it; now and then
  // abandon a partial frame by rewriting a size, or poke a spare register in
  // the middle of a frame (which must not restart it).
  task automatic run_setting(size_t rows_val, size_t cols_val, int unsigned frames);
    int unsigned cells;
    int unsigned split;
    int unsigned pct;
    settle();
    if ($urandom_range(0, 1)) begin
      write_register(CFG_ROW_COUNT, rows_val);
      write_register(CFG_COL_COUNT, cols_val);
    end else begin
      write_register(CFG_COL_COUNT, cols_val);
      write_register(CFG_ROW_COUNT, rows_val);
    end
    @(negedge clk_i);
    cells = eff_size(rows_val, MAX_ROWS) * eff_size(cols_val, MAX_COLS);
    if (cells > 1 && $urandom_range(0, 4) == 0) begin
      queue_cells($urandom_range(1, cells - 1), 50);
      settle();
      if ($urandom_range(0, 1)) write_register(CFG_ROW_COUNT, rows_val);
      else write_register(CFG_COL_COUNT, cols_val);
      @(negedge clk_i);
    end
    repeat (frames) begin
      // Mix solid land, open water and speckled maps.
      pct = ($urandom_range(0, 5) == 0) ? 100 * $urandom_range(0, 1) : $urandom_range(10, 90);
      if (cells > 1 && $urandom_range(0, 5) == 0) begin
        split = $urandom_range(1, cells - 1);
        queue_cells(split, pct);
        settle();
        write_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, size_t'($urandom));
        @(negedge clk_i);
        queue_cells(cells - split, pct);
      end else begin
        queue_cells(cells, pct);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    size_t       rows_val;
    size_t       cols_val;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_ROW_COUNT;
    cfg_ch.data   = '0;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    hold_req      = 0;
    rst_ni        = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero sizes act as a 1 x 1 map, so every cell is a frame.
    write_register(CFG_ROW_COUNT, size_t'(0));
    write_register(CFG_COL_COUNT, size_t'(0));
    @(negedge clk_i);
    land_queue.push_back(1'b1);
    land_queue.push_back(1'b0);
    cells_queued += 2;
    settle();

    // Directed: 3 x 3 maps exercising the single interior cell.
    write_register(CFG_ROW_COUNT, size_t'(3));
    write_register(CFG_COL_COUNT, size_t'(3));
    @(negedge clk_i);
    queue_pattern(9'b111_111_111);  // solid land: interior cell stays inland
    queue_pattern(9'b101_111_111);  // water above the interior cell
    queue_pattern(9'b000_010_000);  // lone island in the middle
    // Abandon a partial frame, then run a ring around a pond.
    queue_pattern(9'b111_111_111);
    land_queue = land_queue[0:31];
    cells_queued -= 4;
    settle();
    write_register(CFG_COL_COUNT, size_t'(3));
    @(negedge clk_i);
    queue_pattern(9'b111_101_111);

    // Size extreme: a single row with the column count clamped to the cap.
    run_setting(size_t'(1), size_t'(2047), 1);

    // Back-pressure: the receiver holds off while 1 x 1 frames keep coming, so
    // the finished count parks and the pixel input stalls.
    run_setting(size_t'(1), size_t'(1), 0);
    send_idle_pct = 0;
    hold_req      <= hold_req + 1;
    queue_cells(40, 50);

    // Random phases, mostly small maps with random content.
    while (cells_queued < ITEM_TARGET) begin
      if (cells_queued + CALM_TAIL >= ITEM_TARGET) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        recv_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      rows_val = ($urandom_range(0, 9) == 0) ? size_t'(0) : size_t'($urandom_range(1, 6));
      case ($urandom_range(0, 9))
        0:       cols_val = size_t'(0);
        1:       cols_val = size_t'($urandom_range(16, 40));
        default: cols_val = size_t'($urandom_range(1, 10));
      endcase
      run_setting(rows_val, cols_val, $urandom_range(1, 4));
    end

    // Drain: wait out every owed count, then watch for stray ones.
    while (land_queue.size() != 0 || pix_ch.valid || expected_counts.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Run covered %0d pixel items and %0d register writes; %0d frame counts compared.",
             cells_queued, reg_writes, counts_checked);
    $display("Map sizes ranged from 1 x 1 to the 1024-column cap, with abandoned and spare-poked frames.");
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Limit: a correct run needs well under a tenth of this.
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bpc_pkg.sv
hdl/bpc_if.sv
hdl/bpc_ram.sv
hdl/boundary_pixel_counter_top.sv
verif/boundary_pixel_counter_top_tb.sv
